// ----- hw/rtl/motor_current_monitor_latch_core_assert.svh -----
// Assertion macros shared by the motor current monitor checker.
`ifndef MOTOR_CURRENT_MONITOR_LATCH_CORE_ASSERT_SVH
`define MOTOR_CURRENT_MONITOR_LATCH_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define MCML_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define MCML_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mcml_pkg.sv -----
// Types, constants and helper functions of the motor current monitor.
package mcml_pkg;

  // Sequencer states: idle, one per use of the shared multiplier, the division step and the finishing steps.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_DIV,
    ST_SCALE,
    ST_DECAY,
    ST_BLEND,
    ST_ACCUM,
    ST_FINAL
  } state_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_LIMIT_ENABLE,
    CFG_CURRENT_LIMIT,
    CFG_CURRENT_GAIN,
    CFG_FILTER_WEIGHT
  } cfg_idx_t;

  localparam int unsigned MUL_A_W = 16;
  localparam int unsigned MUL_B_W = 12;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [7:0]  MAP_SLOPE   = 8'd253;
  localparam logic [7:0]  CUR_MIN     = 8'd1;
  localparam logic [7:0]  CUR_MAX     = 8'd254;
  localparam logic [8:0]  WEIGHT_ONE  = 9'd256;
  localparam logic [7:0]  LIMIT_RESET = 8'd255;
  localparam logic [11:0] GAIN_RESET  = 12'd256;

  // Clamps a non-negative current value onto the 1..254 scale.
  function automatic logic [7:0] clamp_cur(input logic [10:0] v);
    logic [7:0] r;
    if (v < 11'(CUR_MIN)) begin
      r = CUR_MIN;
    end else if (v > 11'(CUR_MAX)) begin
      r = CUR_MAX;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/mcml_mul.sv -----
// Shared unsigned multiplier with a registered product.
module mcml_mul (
  input  logic                          clk,
  input  logic                          en,
  input  logic [mcml_pkg::MUL_A_W-1:0]  a,
  input  logic [mcml_pkg::MUL_B_W-1:0]  b,
  output logic [mcml_pkg::MUL_P_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= mcml_pkg::MUL_P_W'(a) * mcml_pkg::MUL_P_W'(b);
    end
  end

endmodule

// ----- hw/rtl/motor_current_monitor_latch_core.sv -----
// Motor current monitor with scaling, smoothing filter and overcurrent trip latch.
//
// The block takes one raw ADC transaction at a time and returns one result transaction
// for it. After acceptance the work runs through the states MAP, DIV, SCALE, DECAY,
// BLEND, ACCUM and FINAL in turn; in_stall stays high for the whole of that time.
// The steps are set by a single 16 x 12 bit multiplier that is used four times in
// turn (mapping onto the current scale, the gain, the decay of the old filter value
// and the weight of the new reading), with the DIV step for the division by 65535
// and the ACCUM and FINAL steps for finishing the filter and the latch. A finished
// result sits in an output register, so the next sample is accepted while the
// previous result still waits; the last step only stalls when that register is still
// full. Configuration is taken through cfg_we, cfg_index and cfg_wdata at any edge
// and should only be written while the block is idle. Negative ADC words, read as
// two's complement, count as zero; a filter weight above 256 acts as 256.

module motor_current_monitor_latch_core (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_raw_sample,
  input  logic        in_steer_enable,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_filtered_current,
  output logic [7:0]  out_unfiltered_current,
  output logic        out_limit_tripped,
  output logic        out_clear_queued,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);

  // Configuration registers.
  logic        limit_enable_r;
  logic [7:0]  current_limit_r;
  logic [11:0] current_gain_r;
  logic [8:0]  filter_weight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_enable_r  <= 1'b0;
      current_limit_r <= mcml_pkg::LIMIT_RESET;
      current_gain_r  <= mcml_pkg::GAIN_RESET;
      filter_weight_r <= mcml_pkg::WEIGHT_ONE;
    end else if (cfg_we) begin
      case (mcml_pkg::cfg_idx_t'(cfg_index))
        mcml_pkg::CFG_LIMIT_ENABLE:  limit_enable_r  <= cfg_wdata[0];
        mcml_pkg::CFG_CURRENT_LIMIT: current_limit_r <= cfg_wdata[7:0];
        mcml_pkg::CFG_CURRENT_GAIN:  current_gain_r  <= cfg_wdata;
        mcml_pkg::CFG_FILTER_WEIGHT: filter_weight_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  mcml_pkg::state_t state_r, state_nxt;
  logic             out_valid_r;
  logic             out_free;
  logic             in_accept;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != mcml_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcml_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mcml_pkg::ST_IDLE:  if (in_valid) state_nxt = mcml_pkg::ST_MAP;
      mcml_pkg::ST_MAP:   state_nxt = mcml_pkg::ST_DIV;
      mcml_pkg::ST_DIV:   state_nxt = mcml_pkg::ST_SCALE;
      mcml_pkg::ST_SCALE: state_nxt = mcml_pkg::ST_DECAY;
      mcml_pkg::ST_DECAY: state_nxt = mcml_pkg::ST_BLEND;
      mcml_pkg::ST_BLEND: state_nxt = mcml_pkg::ST_ACCUM;
      mcml_pkg::ST_ACCUM: state_nxt = mcml_pkg::ST_FINAL;
      mcml_pkg::ST_FINAL: if (out_free) state_nxt = mcml_pkg::ST_IDLE;
      default:            state_nxt = mcml_pkg::ST_IDLE;
    endcase
  end

  // Captured transaction.
  logic [15:0] raw_r;
  logic        en_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      raw_r <= in_raw_sample;
      en_r  <= in_steer_enable;
    end
  end

  // Negative words in the signed view read as zero.
  logic [15:0] sample_pos;
  assign sample_pos = raw_r[15] ? 16'd0 : raw_r;

  // Weight above one is taken as one; its complement weighs the old value.
  logic [8:0] weight;
  logic [8:0] weight_inv;
  assign weight     = (filter_weight_r > mcml_pkg::WEIGHT_ONE) ? mcml_pkg::WEIGHT_ONE
                                                               : filter_weight_r;
  assign weight_inv = mcml_pkg::WEIGHT_ONE - weight;

  // Shared multiplier and its operand selection.
  logic [mcml_pkg::MUL_A_W-1:0] mul_a;
  logic [mcml_pkg::MUL_B_W-1:0] mul_b;
  logic                         mul_en;
  logic [mcml_pkg::MUL_P_W-1:0] prod_r;
  logic [6:0]                   map_r;
  logic [7:0]                   unf_r;
  logic [15:0]                  ema_r;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (state_r)
      mcml_pkg::ST_MAP: begin
        mul_a = sample_pos;
        mul_b = 12'(mcml_pkg::MAP_SLOPE);
      end
      mcml_pkg::ST_SCALE: begin
        mul_a = 16'(map_r);
        mul_b = current_gain_r;
      end
      mcml_pkg::ST_DECAY: begin
        mul_a = ema_r;
        mul_b = 12'(weight_inv);
      end
      mcml_pkg::ST_BLEND: begin
        mul_a = 16'(unf_r);
        mul_b = 12'(weight);
      end
      default: mul_en = 1'b0;
    endcase
  end

  mcml_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  // Division by 65535 of a product below 2^23: adding the upper half and one
  // before the shift by 16 gives the exact truncated quotient.
  logic [23:0] div_sum;
  logic [6:0]  map_nxt;
  assign div_sum = {1'b0, prod_r[22:0]} + 24'(prod_r[22:16]) + 24'd1;
  assign map_nxt = div_sum[22:16] + 7'd1;

  // Filter update: old part plus the new reading in Q8.8, rounded half up.
  logic [24:0] acc_r;
  logic [25:0] ema_sum;
  logic [15:0] ema_nxt;
  assign ema_sum = {1'b0, acc_r} + {1'b0, prod_r[16:0], 8'd0} + 26'd128;
  assign ema_nxt = ema_sum[23:8];

  // Filtered current, rounded to the nearest whole step and clamped.
  logic [16:0] cur_round;
  logic [7:0]  cur;
  assign cur_round = {1'b0, ema_r} + 17'd128;
  assign cur       = mcml_pkg::clamp_cur(11'(cur_round[16:8]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ema_r <= '0;
    end else if (state_r == mcml_pkg::ST_ACCUM) begin
      ema_r <= ema_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      mcml_pkg::ST_DIV:   map_r <= map_nxt;
      mcml_pkg::ST_DECAY: unf_r <= mcml_pkg::clamp_cur(prod_r[18:8]);
      mcml_pkg::ST_BLEND: acc_r <= prod_r[24:0];
      default: ;
    endcase
  end

  // Trip latch and queued clear. A rising edge of the enable clears the latch
  // at once when the current is already below the limit, otherwise it queues
  // the clear until the current falls; dropping the enable cancels the queue.
  logic trip_r, trip_nxt;
  logic pend_r, pend_nxt;
  logic prev_en_r;
  logic below;

  assign below = (cur < current_limit_r);

  always_comb begin
    trip_nxt = trip_r;
    pend_nxt = pend_r;
    if (limit_enable_r) begin
      if (!below) begin
        trip_nxt = 1'b1;
      end
      if (en_r && !prev_en_r && trip_nxt) begin
        pend_nxt = 1'b1;
        if (below) begin
          trip_nxt = 1'b0;
          pend_nxt = 1'b0;
        end
      end
      if (trip_nxt && pend_nxt && en_r && below) begin
        trip_nxt = 1'b0;
        pend_nxt = 1'b0;
      end
      if (!en_r) begin
        pend_nxt = 1'b0;
      end
    end else begin
      trip_nxt = 1'b0;
      pend_nxt = 1'b0;
    end
  end

  logic finish;
  assign finish = (state_r == mcml_pkg::ST_FINAL) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trip_r    <= 1'b0;
      pend_r    <= 1'b0;
      prev_en_r <= 1'b0;
    end else if (finish) begin
      trip_r    <= trip_nxt;
      pend_r    <= pend_nxt;
      prev_en_r <= en_r;
    end
  end

  // Output register: holds a result until the far side takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_filtered_current   <= cur;
      out_unfiltered_current <= unf_r;
      out_limit_tripped      <= trip_nxt;
      out_clear_queued       <= pend_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/mcml_checker.sv -----
// Port-level assertion checker for the motor current monitor, bound to the top level.
`include "motor_current_monitor_latch_core_assert.svh"

module mcml_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_filtered_current,
  input logic [7:0]  out_unfiltered_current,
  input logic        out_limit_tripped,
  input logic        out_clear_queued
);

  `MCML_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  `MCML_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken again at once")

  `MCML_ASSERT_NOW(a_cur_range, out_valid, (out_filtered_current >= 8'd1) && (out_filtered_current <= 8'd254) && (out_unfiltered_current >= 8'd1) && (out_unfiltered_current <= 8'd254), "current out of range")

  `MCML_ASSERT_NOW(a_queue_needs_trip, out_valid && out_clear_queued, out_limit_tripped, "clear queued without a trip")

endmodule

bind motor_current_monitor_latch_core mcml_checker u_mcml_checker (.*);
